>>> hdl/pfi_pkg.sv
`default_nettype none

package pfi_pkg;

    localparam int MAX_FACTOR         = 8;
    localparam int MAX_TAPS_PER_PHASE = 16;
    localparam int COEF_DEPTH         = MAX_FACTOR * MAX_TAPS_PER_PHASE;
    localparam int COEF_AW            = (COEF_DEPTH > 1) ? $clog2(COEF_DEPTH) : 1;
    localparam int PH_W               = (MAX_FACTOR > 1) ? $clog2(MAX_FACTOR) : 1;
    localparam int TAP_W              = (MAX_TAPS_PER_PHASE > 1) ?
                                        $clog2(MAX_TAPS_PER_PHASE) : 1;

    localparam int SMP_W   = 16;
    localparam int Q_FRAC  = 15;
    localparam int PROD_W  = 2 * SMP_W;
    localparam int ACC_W   = PROD_W + TAP_W + 1;

    localparam int FACTOR_W     = 4;
    localparam int TAPS_W       = 5;
    localparam int CFG_DATA_W   = 5;
    localparam int CFG_IDX_W    = 1;
    localparam int FACTOR_RESET = 1;
    localparam int TAPS_RESET   = 16;

    localparam logic [CFG_IDX_W-1:0] REG_INTERP_FACTOR  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TAPS_PER_PHASE = 1'd1;

    localparam logic [1:0] FUNC_SAMPLE = 2'd0;
    localparam logic [1:0] FUNC_COEF   = 2'd1;
    localparam logic [1:0] FUNC_CLEAR  = 2'd2;

    localparam logic [1:0] CMD_SAMPLE = 2'd0;
    localparam logic [1:0] CMD_COEF   = 2'd1;
    localparam logic [1:0] CMD_CLEAR  = 2'd2;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

    typedef logic [COEF_AW-1:0]       t_caddr;
    typedef logic [PH_W-1:0]          t_ph;
    typedef logic [TAP_W-1:0]         t_tap;
    typedef logic signed [SMP_W-1:0]  t_smp;
    typedef logic signed [PROD_W-1:0] t_prod;
    typedef logic signed [ACC_W-1:0]  t_acc;
    typedef logic [QPTR_W-1:0]        t_qptr;
    typedef logic [QPTR_W:0]          t_qcnt;

    typedef struct packed {
        logic [1:0]        func;
        logic signed [15:0] sample;
        logic [6:0]        coef_index;
        logic signed [15:0] coef_value;
    } t_in;

    typedef struct packed {
        logic signed [15:0] result;
        logic [2:0]        phase;
        logic              last;
    } t_out;

    typedef struct packed {
        logic [1:0] kind;
        t_smp       value;
        t_caddr     index;
    } t_cmd;

    typedef struct packed {
        t_ph  l_m1;
        t_tap p_m1;
    } t_cfg;

    typedef struct packed {
        logic   we;
        t_caddr waddr;
        t_smp   wdata;
        logic   re;
        t_caddr raddr;
    } t_ram_req;

endpackage

`default_nettype wire

>>> hdl/pfi_ram.sv
`default_nettype none

module pfi_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 128
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_we,
    input  wire logic [$clog2(DEPTH)-1:0]         i_waddr,
    input  wire logic [WIDTH-1:0]                 i_wdata,
    input  wire logic                             i_re,
    input  wire logic [$clog2(DEPTH)-1:0]         i_raddr,
    output      logic [WIDTH-1:0]                 o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

>>> hdl/pfi_front.sv
`default_nettype none

module pfi_front (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_valid,
    output      logic          o_stall,
    input  wire pfi_pkg::t_in  i_data,
    output      logic          o_q_valid,
    output      pfi_pkg::t_cmd o_q_cmd,
    input  wire logic          i_q_pop
);

    pfi_pkg::t_cmd  r_mem [pfi_pkg::QUEUE_DEPTH];
    pfi_pkg::t_qptr r_wptr;
    pfi_pkg::t_qptr r_rptr;
    pfi_pkg::t_qcnt r_count;

    logic          full;
    logic          accept;
    logic          keep;
    logic          push;
    logic          pop;
    pfi_pkg::t_cmd cmd;

    assign full   = (r_count == pfi_pkg::t_qcnt'(pfi_pkg::QUEUE_DEPTH));
    assign accept = i_valid && !full;
    assign pop    = i_q_pop && (r_count != '0);

    // Classify the transaction; drop unused codes and out-of-store indexes.
    always_comb begin
        cmd.value = i_data.sample;
        cmd.index = pfi_pkg::t_caddr'(i_data.coef_index);
        cmd.kind  = pfi_pkg::CMD_SAMPLE;
        keep      = 1'b0;
        unique case (i_data.func)
            pfi_pkg::FUNC_SAMPLE: begin
                cmd.kind = pfi_pkg::CMD_SAMPLE;
                keep     = 1'b1;
            end
            pfi_pkg::FUNC_COEF: begin
                cmd.kind  = pfi_pkg::CMD_COEF;
                cmd.value = i_data.coef_value;
                keep      = (32'(i_data.coef_index) < pfi_pkg::COEF_DEPTH);
            end
            pfi_pkg::FUNC_CLEAR: begin
                cmd.kind = pfi_pkg::CMD_CLEAR;
                keep     = 1'b1;
            end
            default: begin
                keep = 1'b0;
            end
        endcase
    end

    assign push = accept && keep;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (push) begin
                r_wptr <= r_wptr + pfi_pkg::t_qptr'(1);
            end
            if (pop) begin
                r_rptr <= r_rptr + pfi_pkg::t_qptr'(1);
            end
            if (push && !pop) begin
                r_count <= r_count + pfi_pkg::t_qcnt'(1);
            end else if (pop && !push) begin
                r_count <= r_count - pfi_pkg::t_qcnt'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wptr] <= cmd;
        end
    end

    assign o_stall   = full;
    assign o_q_valid = (r_count != '0);
    assign o_q_cmd   = r_mem[r_rptr];

endmodule

`default_nettype wire

>>> hdl/pfi_back.sv
`default_nettype none

module pfi_back (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire pfi_pkg::t_cfg     i_cfg,
    input  wire logic              i_q_valid,
    input  wire pfi_pkg::t_cmd     i_q_cmd,
    output      logic              o_q_pop,
    output      pfi_pkg::t_ram_req o_ram,
    input  wire pfi_pkg::t_smp     i_ram_rdata,
    output      logic              o_valid,
    input  wire logic              i_stall,
    output      pfi_pkg::t_out     o_data
);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_RUN  = 1'b1;

    typedef logic signed [pfi_pkg::ACC_W:0] t_accx;

    typedef struct packed {
        logic        first;
        logic        last;
        pfi_pkg::t_ph ph;
        logic        last_ph;
    } t_tag;

    function automatic pfi_pkg::t_smp f_round_sat(input pfi_pkg::t_acc a);
        t_accx v;
        t_accx lim;
        pfi_pkg::t_smp res;
        v   = t_accx'(a) + (t_accx'(1) <<< (pfi_pkg::Q_FRAC - 1));
        lim = t_accx'(1) <<< (2 * pfi_pkg::Q_FRAC);
        if (v >= lim) begin
            res = {1'b0, {(pfi_pkg::SMP_W-1){1'b1}}};
        end else if (v < -lim) begin
            res = {1'b1, {(pfi_pkg::SMP_W-1){1'b0}}};
        end else begin
            res = pfi_pkg::t_smp'(v >>> pfi_pkg::Q_FRAC);
        end
        return res;
    endfunction

    logic                         r_state;
    pfi_pkg::t_smp                r_dl [pfi_pkg::MAX_TAPS_PER_PHASE];
    pfi_pkg::t_tap                r_wp;
    pfi_pkg::t_tap                r_newest;
    pfi_pkg::t_tap                r_pos;
    pfi_pkg::t_tap                r_k;
    pfi_pkg::t_ph                 r_ph;
    pfi_pkg::t_caddr              r_addr;
    logic [pfi_pkg::COEF_DEPTH-1:0] r_cvalid;

    logic          r_s1_valid;
    t_tag          r_s1_tag;
    pfi_pkg::t_smp r_s1_smp;
    logic          r_s1_cv;
    logic          r_s2_valid;
    t_tag          r_s2_tag;
    pfi_pkg::t_prod r_prod;
    pfi_pkg::t_acc r_acc;
    logic          r_s3_valid;
    pfi_pkg::t_ph  r_s3_ph;
    logic          r_s3_last;
    logic          r_o_valid;
    pfi_pkg::t_out r_o_data;

    logic          en;
    logic          pop;
    logic          issue;
    pfi_pkg::t_tap wp_fix;
    pfi_pkg::t_tap n_wp;
    pfi_pkg::t_smp coef;
    t_tag          tag;

    // Freeze the whole MAC pipe only while a finished result is held off.
    assign en     = !(r_o_valid && i_stall);
    assign pop    = (r_state == ST_IDLE) && i_q_valid;
    assign issue  = (r_state == ST_RUN) && en;
    assign wp_fix = (r_wp > i_cfg.p_m1) ? '0 : r_wp;
    assign n_wp   = (wp_fix == i_cfg.p_m1) ? '0 : wp_fix + pfi_pkg::t_tap'(1);
    assign coef   = r_s1_cv ? i_ram_rdata : '0;

    always_comb begin
        tag.first   = (r_k == '0);
        tag.last    = (r_k == i_cfg.p_m1);
        tag.ph      = r_ph;
        tag.last_ph = (r_ph == i_cfg.l_m1);
    end

    always_comb begin
        o_ram.we    = pop && (i_q_cmd.kind == pfi_pkg::CMD_COEF);
        o_ram.waddr = i_q_cmd.index;
        o_ram.wdata = i_q_cmd.value;
        o_ram.re    = issue;
        o_ram.raddr = r_addr;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_wp       <= '0;
            r_cvalid   <= '0;
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
            r_s3_valid <= 1'b0;
            r_o_valid  <= 1'b0;
            for (int i = 0; i < pfi_pkg::MAX_TAPS_PER_PHASE; i++) begin
                r_dl[i] <= '0;
            end
        end else begin
            // Output register is empty or being drained whenever the pipe advances.
            if (en) begin
                r_o_valid <= r_s3_valid;
            end

            if (pop) begin
                unique case (i_q_cmd.kind)
                    pfi_pkg::CMD_SAMPLE: begin
                        r_dl[wp_fix] <= i_q_cmd.value;
                        r_wp         <= n_wp;
                        r_state      <= ST_RUN;
                    end
                    pfi_pkg::CMD_COEF: begin
                        r_cvalid[i_q_cmd.index] <= 1'b1;
                    end
                    pfi_pkg::CMD_CLEAR: begin
                        r_wp <= '0;
                        for (int i = 0; i < pfi_pkg::MAX_TAPS_PER_PHASE; i++) begin
                            r_dl[i] <= '0;
                        end
                    end
                    default: begin
                    end
                endcase
            end

            if (issue && tag.last && tag.last_ph) begin
                r_state <= ST_IDLE;
            end

            if (en) begin
                r_s1_valid <= issue;
                r_s2_valid <= r_s1_valid;
                r_s3_valid <= r_s2_valid && r_s2_tag.last;
            end
        end
    end

    // Sequencer counters and pipeline payload.
    always_ff @(posedge i_clk) begin
        if (pop) begin
            r_newest <= wp_fix;
            r_pos    <= wp_fix;
            r_k      <= '0;
            r_ph     <= '0;
            r_addr   <= '0;
        end else if (issue) begin
            if (tag.last) begin
                r_k    <= '0;
                r_pos  <= r_newest;
                r_ph   <= r_ph + pfi_pkg::t_ph'(1);
                r_addr <= pfi_pkg::t_caddr'(r_ph) + pfi_pkg::t_caddr'(1);
            end else begin
                r_k    <= r_k + pfi_pkg::t_tap'(1);
                r_pos  <= (r_pos == '0) ? i_cfg.p_m1 : r_pos - pfi_pkg::t_tap'(1);
                r_addr <= r_addr + pfi_pkg::t_caddr'(i_cfg.l_m1) + pfi_pkg::t_caddr'(1);
            end
        end

        if (en) begin
            r_s1_tag <= tag;
            r_s1_smp <= r_dl[r_pos];
            r_s1_cv  <= r_cvalid[r_addr];
            r_s2_tag <= r_s1_tag;
            r_prod   <= coef * r_s1_smp;
            if (r_s2_valid) begin
                r_acc <= r_s2_tag.first ? pfi_pkg::t_acc'(r_prod)
                                        : r_acc + pfi_pkg::t_acc'(r_prod);
            end
            r_s3_ph   <= r_s2_tag.ph;
            r_s3_last <= r_s2_tag.last_ph;
            if (r_s3_valid) begin
                r_o_data.result <= f_round_sat(r_acc);
                r_o_data.phase  <= 3'(r_s3_ph);
                r_o_data.last   <= r_s3_last;
            end
        end
    end

    assign o_q_pop = pop;
    assign o_valid = r_o_valid;
    assign o_data  = r_o_data;

    a_issue_feeds_pipe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_RUN) && en |=> r_s1_valid)
        else $error("issued tap did not enter the MAC pipe");

    a_pipe_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !en && r_s2_valid |=> r_s2_valid && $stable(r_prod))
        else $error("MAC pipe moved while output was held");

    a_result_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_o_valid) |-> $past(r_s3_valid))
        else $error("result appeared without a finished sum");

endmodule

`default_nettype wire

>>> hdl/polyphase_fir_interpolator.sv
// Sample transaction in the back end: a pop, then one coefficient read and MAC
// per tap of each of the L phases on the single shared multiplier.
// First result of a sample shows once the taps of phase 0 pass the read, product, accumulator and output registers.
// Coefficient and clear transactions take only the pop in the back end; a two-entry queue
// lets the front accept while the back end works.
// Synchronous active-low reset: delay line and pointer zero, coefficients read
// as zero until written, factor 1, taps per phase 16.
`default_nettype none

module polyphase_fir_interpolator (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_cfg_we,
    input  wire logic [pfi_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  wire logic [pfi_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    input  wire logic                               i_in_valid,
    output      logic                               o_in_stall,
    input  wire pfi_pkg::t_in                       i_in_data,
    output      logic                               o_out_valid,
    input  wire logic                               i_out_stall,
    output      pfi_pkg::t_out                      o_out_data
);

    logic [pfi_pkg::FACTOR_W-1:0] r_factor;
    logic [pfi_pkg::TAPS_W-1:0]   r_taps;
    pfi_pkg::t_cfg                cfg;

    logic              q_valid;
    pfi_pkg::t_cmd     q_cmd;
    logic              q_pop;
    pfi_pkg::t_ram_req ram_req;
    pfi_pkg::t_smp     ram_rdata;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_factor <= pfi_pkg::FACTOR_W'(pfi_pkg::FACTOR_RESET);
            r_taps   <= pfi_pkg::TAPS_W'(pfi_pkg::TAPS_RESET);
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                pfi_pkg::REG_INTERP_FACTOR: begin
                    r_factor <= i_cfg_data[pfi_pkg::FACTOR_W-1:0];
                end
                pfi_pkg::REG_TAPS_PER_PHASE: begin
                    r_taps <= i_cfg_data[pfi_pkg::TAPS_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // Clamp zero up to one and large values down to the maximum; carry value-1.
    always_comb begin
        if (r_factor == '0) begin
            cfg.l_m1 = '0;
        end else if (32'(r_factor) > pfi_pkg::MAX_FACTOR) begin
            cfg.l_m1 = pfi_pkg::t_ph'(pfi_pkg::MAX_FACTOR - 1);
        end else begin
            cfg.l_m1 = pfi_pkg::t_ph'(r_factor - pfi_pkg::FACTOR_W'(1));
        end
        if (r_taps == '0) begin
            cfg.p_m1 = '0;
        end else if (32'(r_taps) > pfi_pkg::MAX_TAPS_PER_PHASE) begin
            cfg.p_m1 = pfi_pkg::t_tap'(pfi_pkg::MAX_TAPS_PER_PHASE - 1);
        end else begin
            cfg.p_m1 = pfi_pkg::t_tap'(r_taps - pfi_pkg::TAPS_W'(1));
        end
    end

    pfi_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_in_valid),
        .o_stall   (o_in_stall),
        .i_data    (i_in_data),
        .o_q_valid (q_valid),
        .o_q_cmd   (q_cmd),
        .i_q_pop   (q_pop)
    );

    pfi_ram #(
        .WIDTH (pfi_pkg::SMP_W),
        .DEPTH (pfi_pkg::COEF_DEPTH)
    ) u_coef_ram (
        .i_clk   (i_clk),
        .i_we    (ram_req.we),
        .i_waddr (ram_req.waddr),
        .i_wdata (ram_req.wdata),
        .i_re    (ram_req.re),
        .i_raddr (ram_req.raddr),
        .o_rdata (ram_rdata)
    );

    pfi_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .i_q_valid   (q_valid),
        .i_q_cmd     (q_cmd),
        .o_q_pop     (q_pop),
        .o_ram       (ram_req),
        .i_ram_rdata (ram_rdata),
        .o_valid     (o_out_valid),
        .i_stall     (i_out_stall),
        .o_data      (o_out_data)
    );

endmodule

`default_nettype wire
